@@ hdl/conv3_pkg.sv @@
// conv3_pkg: shared constants, types and helpers of the 3x3 convolution block
// used by the channel interfaces, the top level and the testbench
package conv3_pkg;

  // geometry and widths
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int PIXEL_BITS   = 8;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int POS_W        = 10;
  localparam int SIZE_W       = 11;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int COEF_W       = 8;
  localparam int PROD_W       = PIXEL_BITS + COEF_W + 1;
  localparam int RSUM_W       = PROD_W + 2;
  localparam int RESULT_W     = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd4;

  // diagonal kernel after reset
  localparam logic [CFG_DATA_W-1:0] KTOP_RST    = 24'h000001;
  localparam logic [CFG_DATA_W-1:0] KMIDDLE_RST = 24'h000100;
  localparam logic [CFG_DATA_W-1:0] KBOTTOM_RST = 24'h010000;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             has;      // at least one result
    logic             tworow;   // last image row: two result rows
    logic             twocol;   // last image column: two result columns
    logic             interior; // upper-left result is an interior position
  } meta_t;

  // saturate a size to 3..hi and return size minus one
  function automatic logic [POS_W-1:0] clamp_last(input logic [SIZE_W-1:0] v,
                                                  input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] t;
    if (v < SIZE_W'(3)) begin
      t = SIZE_W'(2);
    end else if (v > hi) begin
      t = hi - SIZE_W'(1);
    end else begin
      t = v - SIZE_W'(1);
    end
    return t[POS_W-1:0];
  endfunction

  // signed coefficient at position pos (0 left, 1 middle, 2 right)
  function automatic logic signed [COEF_W-1:0] coeff(input logic [CFG_DATA_W-1:0] rowreg,
                                                     input logic [1:0] pos);
    logic [COEF_W-1:0] b;
    case (pos)
      2'd0:    b = rowreg[7:0];
      2'd1:    b = rowreg[15:8];
      2'd2:    b = rowreg[23:16];
      default: b = '0;
    endcase
    return $signed(b);
  endfunction

endpackage

@@ hdl/conv3_in_if.sv @@
// conv3_in_if: pixel input channel, one pixel per beat
// depends on conv3_pkg
interface conv3_in_if;
  logic                            valid;
  logic                            ready;
  logic [conv3_pkg::PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

@@ hdl/conv3_out_if.sv @@
// conv3_out_if: result channel, one result position per beat
// depends on conv3_pkg
interface conv3_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [conv3_pkg::POS_W-1:0]          out_row;
  logic [conv3_pkg::POS_W-1:0]          out_column;
  logic signed [conv3_pkg::RESULT_W-1:0] result_value;
  logic                                 last_of_run;
  logic                                 end_of_image;

  modport source (output valid, output out_row, output out_column, output result_value,
                  output last_of_run, output end_of_image, input ready);
  modport sink (input valid, input out_row, input out_column, input result_value,
                input last_of_run, input end_of_image, output ready);
endinterface

@@ hdl/conv3_cfg_if.sv @@
// conv3_cfg_if: register write channel, index and data per beat
// depends on conv3_pkg
interface conv3_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [conv3_pkg::CFG_IDX_W-1:0]     index;
  logic [conv3_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/conv3x3_zero_border.sv @@
// conv3x3_zero_border: streaming 3x3 convolution with zero border, one pixel per cycle.
// A pixel's first result passes the ram read, window, products, row sums and result register.
// Throughput: one pixel per cycle; a pixel in the last column or last row yields up to 2
// results, the last pixel of the image 4, one per output cycle, and the input stalls once the
// pipeline behind them fills. Reset (rst_n low, synchronous): position 0,0, 1024x1024,
// diagonal kernel, empty pipeline; lines not cleared.
module conv3x3_zero_border (
  input  logic  clk,
  input  logic  rst_n,
  conv3_in_if.sink   in_ch,
  conv3_out_if.source out_ch,
  conv3_cfg_if.sink  cfg_ch
);

  localparam int PB = conv3_pkg::PIXEL_BITS;
  localparam int PW = conv3_pkg::POS_W;

  // configuration registers
  logic [PW-1:0]                    wlast_r, hlast_r;
  logic [conv3_pkg::CFG_DATA_W-1:0] ktop_r, kmid_r, kbot_r;
  logic [conv3_pkg::CFG_DATA_W-1:0] krows [3];
  logic                             size_wr;

  // input position
  logic [PW-1:0] col_r, row_r;

  // pipeline control
  logic in_acc, s1_ready, s2_ready, s3_ready, s4_ready, e_ready;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, e_v_r;
  conv3_pkg::meta_t s1_m_r, s2_m_r, s3_m_r, s4_m_r, s1_m_nxt;

  // datapath
  logic [PB-1:0]      s1_pix_r;
  logic [2*PB-1:0]    ram_rdata;
  logic               ram_we;
  logic [PB-1:0]      win_r [3][3];
  logic signed [conv3_pkg::PROD_W-1:0] prod_r [3][3];
  logic signed [conv3_pkg::PROD_W-1:0] prod_nxt [3][3];
  logic signed [conv3_pkg::RSUM_W-1:0] rsum_r [3];
  logic signed [conv3_pkg::RSUM_W-1:0] rsum_nxt [3];
  logic signed [conv3_pkg::RSUM_W:0]   total;

  // emitter
  logic [PW-1:0]                          e_row_r, e_col_r;
  logic                                   e_tworow_r, e_twocol_r, e_int_r;
  logic                                   e_a_r, e_b_r;
  logic signed [conv3_pkg::RESULT_W-1:0]  e_sum_r;
  logic                                   out_last, out_acc;

  assign krows[0] = ktop_r;
  assign krows[1] = kmid_r;
  assign krows[2] = kbot_r;

  // handshakes and stage readiness
  assign cfg_ch.ready = 1'b1;
  assign size_wr  = cfg_ch.valid &&
                    (cfg_ch.index inside {conv3_pkg::CFG_IMAGE_WIDTH,
                                          conv3_pkg::CFG_IMAGE_HEIGHT});
  assign out_last = (e_a_r == e_tworow_r) && (e_b_r == e_twocol_r);
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign e_ready  = !e_v_r || (out_ch.ready && out_last);
  assign s4_ready = !s4_v_r || e_ready;
  assign s3_ready = !s3_v_r || s4_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign ram_we = s1_v_r && s2_ready;

  // configuration writes and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= PW'(conv3_pkg::MAX_WIDTH - 1);
      hlast_r <= PW'(conv3_pkg::HEIGHT_LIMIT - 1);
      ktop_r  <= conv3_pkg::KTOP_RST;
      kmid_r  <= conv3_pkg::KMIDDLE_RST;
      kbot_r  <= conv3_pkg::KBOTTOM_RST;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          conv3_pkg::CFG_IMAGE_WIDTH: begin
            wlast_r <= conv3_pkg::clamp_last(cfg_ch.data[conv3_pkg::SIZE_W-1:0],
                                             conv3_pkg::SIZE_W'(conv3_pkg::MAX_WIDTH));
          end
          conv3_pkg::CFG_IMAGE_HEIGHT: begin
            hlast_r <= conv3_pkg::clamp_last(cfg_ch.data[conv3_pkg::SIZE_W-1:0],
                                             conv3_pkg::SIZE_W'(conv3_pkg::HEIGHT_LIMIT));
          end
          conv3_pkg::CFG_KERNEL_TOP:    ktop_r <= cfg_ch.data;
          conv3_pkg::CFG_KERNEL_MIDDLE: kmid_r <= cfg_ch.data;
          conv3_pkg::CFG_KERNEL_BOTTOM: kbot_r <= cfg_ch.data;
          default: ;
        endcase
      end
      // a size write restarts the image, otherwise each pixel beat advances
      if (size_wr) begin
        col_r <= '0;
        row_r <= '0;
      end else if (in_acc) begin
        if (col_r == wlast_r) begin
          col_r <= '0;
          row_r <= (row_r == hlast_r) ? '0 : row_r + PW'(1);
        end else begin
          col_r <= col_r + PW'(1);
        end
      end
    end
  end

  // line buffers: each word holds {older line, newer line} of one column
  conv3_ram #(
    .WIDTH (2 * PB),
    .DEPTH (conv3_pkg::MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_m_r.col[conv3_pkg::ADDR_W-1:0]),
    .wdata ({ram_rdata[PB-1:0], s1_pix_r}),
    .re    (in_acc),
    .raddr (col_r[conv3_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // stage 1 control for the accepted beat
  always_comb begin
    s1_m_nxt.row      = row_r;
    s1_m_nxt.col      = col_r;
    s1_m_nxt.has      = (row_r != '0) && (col_r != '0);
    s1_m_nxt.tworow   = (row_r == hlast_r);
    s1_m_nxt.twocol   = (col_r == wlast_r);
    s1_m_nxt.interior = (row_r >= PW'(2)) && (col_r >= PW'(2));
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= in_acc;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (s3_ready) s3_v_r <= s2_v_r;
      if (s4_ready) s4_v_r <= s3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_ch.pixel;
      s1_m_r   <= s1_m_nxt;
    end
    if (s2_ready) s2_m_r <= s1_m_r;
    if (s3_ready) s3_m_r <= s2_m_r;
    if (s4_ready) s4_m_r <= s3_m_r;
  end

  // window shift with the new column from the line buffers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          win_r[k][m] <= '0;
        end
      end
    end else if (ram_we) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= ram_rdata[2*PB-1:PB];
      win_r[1][2] <= ram_rdata[PB-1:0];
      win_r[2][2] <= s1_pix_r;
    end
  end

  // nine pixel times coefficient products
  always_comb begin
    logic signed [conv3_pkg::PROD_W-1:0] pa, ka;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        pa = $signed({{(conv3_pkg::PROD_W - PB){1'b0}}, win_r[k][m]});
        ka = conv3_pkg::PROD_W'(conv3_pkg::coeff(krows[k], 2'(m)));
        prod_nxt[k][m] = pa * ka;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) prod_r <= prod_nxt;
  end

  // per-row sums
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsum_nxt[k] = conv3_pkg::RSUM_W'(prod_r[k][0]) + conv3_pkg::RSUM_W'(prod_r[k][1])
                  + conv3_pkg::RSUM_W'(prod_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready) rsum_r <= rsum_nxt;
  end

  assign total = (conv3_pkg::RSUM_W + 1)'(rsum_r[0]) + (conv3_pkg::RSUM_W + 1)'(rsum_r[1])
               + (conv3_pkg::RSUM_W + 1)'(rsum_r[2]);

  // result emitter: up to four beats per pixel, row by row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      e_a_r <= 1'b0;
      e_b_r <= 1'b0;
    end else if (e_ready) begin
      e_v_r <= s4_v_r && s4_m_r.has;
      e_a_r <= 1'b0;
      e_b_r <= 1'b0;
    end else if (out_acc) begin
      if (!e_b_r && e_twocol_r) begin
        e_b_r <= 1'b1;
      end else begin
        e_a_r <= 1'b1;
        e_b_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready) begin
      e_row_r    <= s4_m_r.row;
      e_col_r    <= s4_m_r.col;
      e_tworow_r <= s4_m_r.tworow;
      e_twocol_r <= s4_m_r.twocol;
      e_int_r    <= s4_m_r.interior;
      e_sum_r    <= total[conv3_pkg::RESULT_W-1:0];
    end
  end

  // output beat fields
  assign out_ch.valid        = e_v_r;
  assign out_ch.out_row      = e_a_r ? e_row_r : e_row_r - PW'(1);
  assign out_ch.out_column   = e_b_r ? e_col_r : e_col_r - PW'(1);
  assign out_ch.result_value = (!e_a_r && !e_b_r && e_int_r) ? e_sum_r : '0;
  assign out_ch.last_of_run  = out_last;
  assign out_ch.end_of_image = e_tworow_r && e_twocol_r && e_a_r && e_b_r;

`ifndef SYNTH
  // line buffer read never hits the column being written back
  a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && in_acc) |-> (s1_m_r.col != col_r))
    else $error("line buffer read and write hit the same column");

  // second result row only on the last image row
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (e_v_r && e_a_r) |-> e_tworow_r)
    else $error("emitter stepped to a second row that does not exist");

  // end of image is always the last beat of its pixel
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_image) |-> out_ch.last_of_run)
    else $error("end of image on a beat that is not last of run");

  // only the upper-left result of a pixel may be nonzero
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (e_a_r || e_b_r)) |-> (out_ch.result_value == '0))
    else $error("nonzero value on a border position");

  // input position stays inside the image
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= wlast_r) && (row_r <= hlast_r))
    else $error("input position outside the image");
`endif

endmodule

@@ hdl/conv3_ram.sv @@
// conv3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module conv3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ tb/conv3x3_result_checker.sv @@
// conv3x3_result_checker: watches the pixel, register and result channels of the
// 3x3 convolution block, predicts every result position and compares it
// depends on conv3_pkg and the three channel interfaces
module conv3x3_result_checker
  import conv3_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  conv3_in_if   in_mon,
  conv3_out_if  out_mon,
  conv3_cfg_if  cfg_mon,
  output int    fail_count,
  output int    points_left,
  output int    points_checked
);

  localparam int PRINT_CAP = 40;

  // one result position as it should leave the block
  typedef struct packed {
    logic [POS_W-1:0]           row;
    logic [POS_W-1:0]           column;
    logic signed [RESULT_W-1:0] value;
    logic                       last_px;
    logic                       image_end;
  } conv_point_t;

  conv_point_t awaited_points[$];

  // predicted block state
  logic [SIZE_W-1:0]     width_reg;
  logic [SIZE_W-1:0]     height_reg;
  logic [CFG_DATA_W-1:0] kern [3];
  logic [PIXEL_BITS-1:0] older_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] newer_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] win [3][3];
  int                    next_row;
  int                    next_col;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("%0t conv3x3 check: %s", $time, what);
    end
  endtask

  // size register saturated to 3..hi
  function automatic int size_limit(input logic [SIZE_W-1:0] v, input int hi);
    if (int'(v) < 3) return 3;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  // signed kernel applied to the current window, kept to the result width
  function automatic logic [RESULT_W-1:0] weighted_sum();
    int acc;
    logic signed [COEF_W-1:0] k;
    acc = 0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        k = kern[a][COEF_W*b +: COEF_W];
        acc += int'(k) * int'(win[a][b]);
      end
    end
    return acc[RESULT_W-1:0];
  endfunction

  // register beat
  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = d[SIZE_W-1:0];
        next_row = 0;
        next_col = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = d[SIZE_W-1:0];
        next_row = 0;
        next_col = 0;
      end
      CFG_KERNEL_TOP:    kern[0] = d;
      CFG_KERNEL_MIDDLE: kern[1] = d;
      CFG_KERNEL_BOTTOM: kern[2] = d;
      default: ;
    endcase
  endtask

  // pixel beat: shift window, update line buffers, queue the positions it completes
  task automatic absorb_pixel(input logic [PIXEL_BITS-1:0] px);
    int w, h, i, j, nr, nc;
    int rl [2];
    int cl [2];
    bit interior;
    conv_point_t e;
    w = size_limit(width_reg, MAX_WIDTH);
    h = size_limit(height_reg, HEIGHT_LIMIT);
    i = (next_row >= h) ? h - 1 : next_row;
    j = (next_col >= w) ? w - 1 : next_col;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = older_row[j];
    win[1][2] = newer_row[j];
    win[2][2] = px;
    older_row[j] = newer_row[j];
    newer_row[j] = px;

    // rows and columns finished by this pixel
    nr = 0;
    nc = 0;
    if (i > 0) begin
      rl[nr] = i - 1;
      nr++;
      if (i == h - 1) begin
        rl[nr] = i;
        nr++;
      end
    end
    if (j > 0) begin
      cl[nc] = j - 1;
      nc++;
      if (j == w - 1) begin
        cl[nc] = j;
        nc++;
      end
    end

    for (int a = 0; a < nr; a++) begin
      for (int b = 0; b < nc; b++) begin
        interior = rl[a] >= 1 && rl[a] <= h - 2 && cl[b] >= 1 && cl[b] <= w - 2;
        e.row = POS_W'(rl[a]);
        e.column = POS_W'(cl[b]);
        e.value = interior ? weighted_sum() : '0;
        e.last_px = (a == nr - 1) && (b == nc - 1);
        e.image_end = (rl[a] == h - 1) && (cl[b] == w - 1);
        awaited_points.push_back(e);
      end
    end

    // advance the raster position, wrapping at the image end
    j++;
    if (j >= w) begin
      j = 0;
      i++;
      if (i >= h) i = 0;
    end
    next_row = i;
    next_col = j;
  endtask

  // result beat against the oldest expectation
  task automatic match_point();
    conv_point_t seen, want;
    seen.row = out_mon.out_row;
    seen.column = out_mon.out_column;
    seen.value = out_mon.result_value;
    seen.last_px = out_mon.last_of_run;
    seen.image_end = out_mon.end_of_image;
    points_checked++;
    if (awaited_points.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                seen.row, seen.column, $signed(seen.value)));
    end else begin
      want = awaited_points.pop_front();
      if (seen !== want) begin
        report_mismatch($sformatf(
          "got r%0d c%0d v%0d l%0b e%0b, expected r%0d c%0d v%0d l%0b e%0b",
          seen.row, seen.column, $signed(seen.value), seen.last_px, seen.image_end,
          want.row, want.column, $signed(want.value), want.last_px, want.image_end));
      end
    end
  endtask

  // sample all channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg <= SIZE_W'(MAX_WIDTH);
      height_reg <= SIZE_W'(HEIGHT_LIMIT);
      kern[0] <= KTOP_RST;
      kern[1] <= KMIDDLE_RST;
      kern[2] <= KBOTTOM_RST;
      for (int k = 0; k < 9; k++) begin
        win[k / 3][k % 3] <= '0;
      end
      for (int k = 0; k < MAX_WIDTH; k++) begin
        older_row[k] <= '0;
        newer_row[k] <= '0;
      end
      next_row <= 0;
      next_col <= 0;
      fail_count <= 0;
      points_left <= 0;
      points_checked <= 0;
      awaited_points.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) match_point();
      if (cfg_mon.valid && cfg_mon.ready) apply_write(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready) absorb_pixel(in_mon.pixel);
      points_left = awaited_points.size();
    end
  end

endmodule

@@ tb/conv3x3_zero_border_tb.sv @@
// conv3x3_zero_border_tb: drives pixel streams and register writes into the 3x3
// convolution block with random idling; depends on conv3_pkg, the channel
// interfaces, the block and conv3x3_result_checker
module conv3x3_zero_border_tb;
  import conv3_pkg::*;

  localparam int     HALF_PERIOD  = 5;
  localparam int     RESET_CYCLES = 7;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     LONG_HOLD    = 300;
  localparam int     RANDOM_PIXELS = 150;
  localparam int     WIDE_PIXELS  = 20;
  localparam int     TALL_PIXELS  = 30;
  localparam longint RUN_LIMIT    = 64'd80_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REGISTER = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int fail_count;
  int points_left;
  int points_checked;
  int pixel_beats;
  int reg_writes;

  // sender and receiver idling state
  int send_calm_left;
  bit send_calm;
  int rdy_gap_left;
  int rdy_calm_left;
  bit rdy_calm;
  int hold_left;
  bit hold_req;
  bit hold_done;

  conv3_in_if  in_ch ();
  conv3_out_if out_ch ();
  conv3_cfg_if cfg_ch ();

  always #HALF_PERIOD clk = ~clk;

  conv3x3_zero_border uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  conv3x3_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .fail_count     (fail_count),
    .points_left    (points_left),
    .points_checked (points_checked)
  );

  // idle length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // result-side ready: random gaps, calm stretches and one long hold once results wait
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rdy_gap_left <= 0;
      rdy_calm_left <= 0;
      rdy_calm <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (rdy_calm_left == 0) begin
        rdy_calm <= ($urandom_range(0, 2) == 0);
        rdy_calm_left <= $urandom_range(20, 200);
      end else begin
        rdy_calm_left <= rdy_calm_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= (hold_left == 1);
      end else if (hold_req && !hold_done && out_ch.valid) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (rdy_gap_left != 0) begin
        rdy_gap_left <= rdy_gap_left - 1;
        out_ch.ready <= (rdy_gap_left == 1);
      end else if (!rdy_calm && $urandom_range(0, 3) == 0) begin
        rdy_gap_left <= gap_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one pixel beat, with an optional idle gap in front
  task automatic push_pixel(input logic [PIXEL_BITS-1:0] px);
    int gap;
    if (send_calm_left == 0) begin
      send_calm = ($urandom_range(0, 2) == 0);
      send_calm_left = $urandom_range(16, 160);
    end
    send_calm_left--;
    gap = (!send_calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel <= px;
    do @(posedge clk); while (!in_ch.ready);
    pixel_beats++;
  endtask

  // pixel values leaning toward the extremes
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  task automatic push_pixels(input int n);
    for (int k = 0; k < n; k++) begin
      push_pixel(pick_pixel());
    end
  endtask

  // one register beat, with the channel dropped afterwards
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // size writes carry random bits above the register width
  task automatic set_size(input logic [SIZE_W-1:0] wv, input logic [SIZE_W-1:0] hv);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    d[SIZE_W-1:0] = wv;
    cfg_write(CFG_IMAGE_WIDTH, d);
    d = $urandom;
    d[SIZE_W-1:0] = hv;
    cfg_write(CFG_IMAGE_HEIGHT, d);
  endtask

  task automatic set_kernel(input logic [CFG_DATA_W-1:0] t, input logic [CFG_DATA_W-1:0] m,
                            input logic [CFG_DATA_W-1:0] b);
    cfg_write(CFG_KERNEL_TOP, t);
    cfg_write(CFG_KERNEL_MIDDLE, m);
    cfg_write(CFG_KERNEL_BOTTOM, b);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_kernel_row();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 24'h808080;
      3:       return 24'h7F7F7F;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // stop sending, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (points_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int ew, eh, n, pick, rand_pixels;
    logic [SIZE_W-1:0] wv, hv;
    in_ch.valid <= 1'b0;
    in_ch.pixel <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_IMAGE_WIDTH;
    cfg_ch.data <= '0;
    hold_req <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry, first row only: no positions complete yet
    push_pixel('0);
    push_pixel('1);
    settle();

    // smallest image, reset diagonal kernel, checkerboard of extremes
    set_size(SIZE_W'(3), SIZE_W'(3));
    for (int k = 0; k < 9; k++) begin
      push_pixel((k % 2 == 0) ? '1 : '0);
    end
    settle();

    // most negative and most positive weighted sums
    set_kernel(24'h808080, 24'h808080, 24'h808080);
    for (int k = 0; k < 9; k++) push_pixel('1);
    settle();
    set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    for (int k = 0; k < 9; k++) push_pixel('1);
    settle();

    // saturated sizes: start of a 1024 wide image, then ten rows of a 3 wide image
    // that meets a long result-side hold while pixels keep coming
    set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    set_size(SIZE_W'(2047), SIZE_W'(0));
    push_pixels(WIDE_PIXELS);
    settle();
    set_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    set_size(SIZE_W'(1), SIZE_W'(2047));
    hold_req <= 1'b1;
    push_pixels(TALL_PIXELS);
    settle();

    // random small images
    rand_pixels = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      ew = $urandom_range(3, 12);
      eh = $urandom_range(3, 8);
      wv = (ew == 3 && $urandom_range(0, 1) == 1) ? SIZE_W'($urandom_range(0, 2)) : SIZE_W'(ew);
      hv = (eh == 3 && $urandom_range(0, 1) == 1) ? SIZE_W'($urandom_range(0, 2)) : SIZE_W'(eh);
      if ($urandom_range(0, 5) != 0 || rand_pixels == 0) set_size(wv, hv);
      if ($urandom_range(0, 1) == 1) cfg_write(CFG_KERNEL_TOP, pick_kernel_row());
      if ($urandom_range(0, 1) == 1) cfg_write(CFG_KERNEL_MIDDLE, pick_kernel_row());
      if ($urandom_range(0, 1) == 1) cfg_write(CFG_KERNEL_BOTTOM, pick_kernel_row());
      if ($urandom_range(0, 5) == 0) begin
        cfg_write(CFG_NO_REGISTER - CFG_IDX_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom));
      end
      // whole image mostly, sometimes cut short or two in a row
      pick = $urandom_range(0, 19);
      n = ew * eh;
      if (pick < 3) begin
        n = $urandom_range(1, n - 1);
      end else if (pick < 6) begin
        n = 2 * n;
      end
      push_pixels(n);
      rand_pixels += n;
      settle();
    end

    $display("covered %0d pixel beats, %0d result positions and %0d register writes,",
             pixel_beats, points_checked, reg_writes);
    $display("small random images, sizes saturated at both ends, extreme kernels, long hold");
    if (fail_count == 0 && points_left == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop if the run hangs
  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
